[rtl/core/gcpv_pkg.sv]
// package: request and result words, command codes and sequencer states
package gcpv_pkg;

  // frame store geometry, powers of two so that wrapping is a mask
  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 512;

  typedef enum logic [1:0] {
    REQ_GP0  = 2'd0,
    REQ_GP1  = 2'd1,
    REQ_STAT = 2'd2,
    REQ_PEEK = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] bus_word;
    logic [9:0]  peek_x;
    logic [8:0]  peek_y;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        copy_active;
    logic [1:0]  args_pending;
    logic        display_on;
    logic [9:0]  disp_start_x;
    logic [8:0]  disp_start_y;
    logic [11:0] hrange_start;
    logic [11:0] hrange_end;
    logic [9:0]  vrange_start;
    logic [9:0]  vrange_end;
    logic [6:0]  mode_bits;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX0,
    ST_PIX1,
    ST_FILL,
    ST_CLEAR,
    ST_PEEK,
    ST_DONE,
    ST_INIT
  } state_e;

  // memory write/read request from the sequencer to the frame store
  typedef struct packed {
    logic        we;
    logic [9:0]  wx;
    logic [8:0]  wy;
    logic [15:0] wdata;
    logic [9:0]  rx;
    logic [8:0]  ry;
  } mem_req_t;

  localparam logic [31:0] STATUS_WORD = 32'h1C00_0000;
  localparam logic [7:0]  OP_FILL     = 8'h02;
  localparam logic [7:0]  OP_COPY     = 8'hA0;
  localparam logic [7:0]  GP1_RESET   = 8'h00;
  localparam logic [7:0]  GP1_DISP_EN = 8'h03;
  localparam logic [7:0]  GP1_START   = 8'h05;
  localparam logic [7:0]  GP1_HRANGE  = 8'h06;
  localparam logic [7:0]  GP1_VRANGE  = 8'h07;
  localparam logic [7:0]  GP1_MODE    = 8'h08;
  localparam logic [11:0] H_START_RST = 12'h260;
  localparam logic [11:0] H_END_RST   = 12'hC60;
  localparam logic [9:0]  V_START_RST = 10'h010;
  localparam logic [9:0]  V_END_RST   = 10'h100;

endpackage

[rtl/core/gcpv_vram.sv]
// frame store: one write port, one registered read port
module gcpv_vram (
  input  logic               clk_i,
  input  gcpv_pkg::mem_req_t req_i,
  output logic [15:0]        rdata_o
);
  import gcpv_pkg::*;

  localparam int XW = $clog2(FRAME_WIDTH);
  localparam int YW = $clog2(FRAME_HEIGHT);

  logic [15:0] mem [FRAME_WIDTH*FRAME_HEIGHT];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[{req_i.wy[YW-1:0], req_i.wx[XW-1:0]}] <= req_i.wdata;
    end
    rdata_o <= mem[{req_i.ry[YW-1:0], req_i.rx[XW-1:0]}];
  end
endmodule

[rtl/core/gcpv_seq.sv]
// sequencer: command decode, argument capture, fill/copy/clear address stepping
module gcpv_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  gcpv_pkg::req_t     req_i,
  input  logic [15:0]        rdata_i,
  output logic               busy_o,
  output logic               done_o,
  output gcpv_pkg::rsp_t     rsp_o,
  output gcpv_pkg::mem_req_t mem_o
);
  import gcpv_pkg::*;

  localparam int XW = $clog2(FRAME_WIDTH);
  localparam int YW = $clog2(FRAME_HEIGHT);
  localparam logic [9:0] XMAX = 10'(FRAME_WIDTH - 1);
  localparam logic [8:0] YMAX = 9'(FRAME_HEIGHT - 1);

  state_e state_q, state_d;
  logic [31:0] cmd_q, arg0_q;
  logic [1:0]  wanted_q, got_q;
  logic        xon_q;
  logic [9:0]  xx_q, xw_q, xcol_q;
  logic [8:0]  xy_q, xh_q, xrow_q;
  logic [31:0] word_q;
  logic [31:0] rd_q;
  logic        dsp_en_q;
  logic [9:0]  dsx_q;
  logic [8:0]  dsy_q;
  logic [11:0] hs_q, he_q;
  logic [9:0]  vs_q, ve_q;
  logic [6:0]  mode_q;
  // fill / clear walker
  logic [9:0]  fx0_q, fw_q, fj_q;
  logic [8:0]  fy0_q, fh_q, fi_q;
  logic [15:0] fc_q;
  logic [18:0] clr_q;

  logic [7:0] op_w;
  assign op_w = req_i.bus_word[31:24];

  // copy step helpers
  logic [9:0]  col_inc;
  logic [8:0]  row_inc;
  logic        col_wrap, row_end;
  assign col_inc  = xcol_q + 10'd1;
  assign col_wrap = ({1'b0, col_inc} >= {1'b0, xw_q});
  assign row_inc  = xrow_q + 9'd1;
  assign row_end  = col_wrap && (row_inc >= xh_q);

  // fill width from the size word, rounded up to 16
  logic [10:0] fw_raw;
  logic [10:0] fw_rnd;
  assign fw_raw = {1'b0, req_i.bus_word[9:0]};

  logic fj_last, fi_last;
  assign fj_last = ({1'b0, fj_q} + 11'd1) >= {fw_q == 10'd0, fw_q};
  assign fi_last = (fi_q + 9'd1) >= fh_q;
  logic clr_last;
  assign clr_last = (clr_q == 19'((FRAME_WIDTH*FRAME_HEIGHT) - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) begin
        state_d = ST_DONE;
        case (req_i.req_type)
          REQ_GP0: begin
            if (xon_q) state_d = ST_PIX0;
          end
          REQ_GP1: if (op_w == GP1_RESET) state_d = ST_CLEAR;
          REQ_PEEK: state_d = ST_PEEK;
          default: state_d = ST_DONE;
        endcase
      end
      ST_PIX0:  state_d = (row_end || !xon_q) ? ST_DONE : ST_PIX1;
      ST_PIX1:  state_d = ST_DONE;
      ST_FILL:  if (fj_last && fi_last) state_d = ST_DONE;
      ST_CLEAR: if (clr_last) state_d = ST_DONE;
      ST_INIT:  if (clr_last) state_d = ST_IDLE;
      ST_PEEK:  state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
    // argument completion of a fill enters the walker
    if (state_q == ST_IDLE && start_i && req_i.req_type == REQ_GP0 && !xon_q &&
        wanted_q != 2'd0 && got_q == 2'd1 && cmd_q[31:24] == OP_FILL &&
        req_i.bus_word[24:16] != 9'd0 && req_i.bus_word[9:0] != 10'd0)
      state_d = ST_FILL;
  end

  // pixel reads address the store straight from the request, data lands in st_peek
  always_comb begin
    mem_o       = '0;
    mem_o.rx    = req_i.peek_x;
    mem_o.ry    = req_i.peek_y;
    case (state_q)
      ST_PIX0: begin
        mem_o.we    = xon_q;
        mem_o.wx    = 10'(11'(xx_q) + 11'(xcol_q)) & XMAX;
        mem_o.wy    = 9'(10'(xy_q) + 10'(xrow_q)) & YMAX;
        mem_o.wdata = word_q[15:0];
      end
      ST_PIX1: begin
        mem_o.we    = xon_q;
        mem_o.wx    = 10'(11'(xx_q) + 11'(xcol_q)) & XMAX;
        mem_o.wy    = 9'(10'(xy_q) + 10'(xrow_q)) & YMAX;
        mem_o.wdata = word_q[31:16];
      end
      ST_FILL: begin
        mem_o.we    = 1'b1;
        mem_o.wx    = 10'(11'(fx0_q) + 11'(fj_q)) & XMAX;
        mem_o.wy    = 9'(10'(fy0_q) + 10'(fi_q)) & YMAX;
        mem_o.wdata = fc_q;
      end
      ST_CLEAR, ST_INIT: begin
        mem_o.we    = 1'b1;
        mem_o.wx    = 10'(clr_q[XW-1:0]);
        mem_o.wy    = 9'(clr_q[XW+YW-1:XW]);
      end
      default: ;
    endcase
  end

  assign fw_rnd = (fw_raw + 11'd15) & 11'h7F0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cmd_q <= '0; arg0_q <= '0; wanted_q <= '0; got_q <= '0;
      xon_q <= 1'b0; xx_q <= '0; xw_q <= '0; xcol_q <= '0;
      xy_q <= '0; xh_q <= '0; xrow_q <= '0;
      dsp_en_q <= 1'b0; dsx_q <= '0; dsy_q <= '0;
      hs_q <= H_START_RST; he_q <= H_END_RST;
      vs_q <= V_START_RST; ve_q <= V_END_RST; mode_q <= '0;
      fi_q <= '0; fj_q <= '0; clr_q <= '0;
      fx0_q <= '0; fy0_q <= '0; fw_q <= '0; fh_q <= '0; fc_q <= '0;
      word_q <= '0;
      rd_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: if (start_i) begin
          word_q <= req_i.bus_word;
          rd_q   <= (req_i.req_type == REQ_STAT) ? STATUS_WORD : 32'd0;
          fi_q <= '0; fj_q <= '0; clr_q <= '0;
          case (req_i.req_type)
            REQ_GP0: if (!xon_q) begin
              if (wanted_q != 2'd0) begin
                if (got_q == 2'd0) begin
                  arg0_q <= req_i.bus_word;
                  got_q  <= 2'd1;
                end else begin
                  wanted_q <= '0;
                  got_q    <= '0;
                  if (cmd_q[31:24] == OP_FILL) begin
                    fc_q  <= {1'b0, cmd_q[23:19], cmd_q[15:11], cmd_q[7:3]};
                    fx0_q <= arg0_q[9:0] & 10'h3F0;
                    fy0_q <= arg0_q[24:16];
                    fw_q  <= fw_rnd[9:0];
                    fh_q  <= req_i.bus_word[24:16];
                  end else begin
                    xx_q <= arg0_q[9:0]; xy_q <= arg0_q[24:16];
                    xw_q <= req_i.bus_word[9:0]; xh_q <= req_i.bus_word[24:16];
                    xcol_q <= '0; xrow_q <= '0;
                    xon_q <= (req_i.bus_word[9:0] != 10'd0) &&
                             (req_i.bus_word[24:16] != 9'd0);
                  end
                end
              end else if (op_w == OP_FILL || op_w == OP_COPY) begin
                cmd_q <= req_i.bus_word; wanted_q <= 2'd2; got_q <= '0;
              end
            end
            REQ_GP1: begin
              case (op_w)
                GP1_RESET: begin
                  cmd_q <= '0; arg0_q <= '0; wanted_q <= '0; got_q <= '0;
                  xon_q <= 1'b0; xx_q <= '0; xw_q <= '0; xcol_q <= '0;
                  xy_q <= '0; xh_q <= '0; xrow_q <= '0;
                  dsp_en_q <= 1'b0; dsx_q <= '0; dsy_q <= '0;
                  hs_q <= H_START_RST; he_q <= H_END_RST;
                  vs_q <= V_START_RST; ve_q <= V_END_RST; mode_q <= '0;
                end
                GP1_DISP_EN: dsp_en_q <= ~req_i.bus_word[0];
                GP1_START: begin
                  dsx_q <= req_i.bus_word[9:0]; dsy_q <= req_i.bus_word[18:10];
                end
                GP1_HRANGE: begin
                  hs_q <= req_i.bus_word[11:0]; he_q <= req_i.bus_word[23:12];
                end
                GP1_VRANGE: begin
                  vs_q <= req_i.bus_word[9:0]; ve_q <= req_i.bus_word[19:10];
                end
                GP1_MODE: mode_q <= req_i.bus_word[6:0];
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        ST_PIX0, ST_PIX1: if (xon_q) begin
          xcol_q <= col_wrap ? 10'd0 : col_inc;
          if (col_wrap) begin
            xrow_q <= row_inc;
            if (row_inc >= xh_q) xon_q <= 1'b0;
          end
        end
        ST_FILL: begin
          fj_q <= fj_last ? 10'd0 : fj_q + 10'd1;
          if (fj_last) fi_q <= fi_q + 9'd1;
        end
        ST_CLEAR, ST_INIT: clr_q <= clr_q + 19'd1;
        ST_PEEK:  rd_q  <= {16'd0, rdata_i};
        default: ;
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  always_comb begin
    rsp_o.read_data    = rd_q;
    rsp_o.copy_active  = xon_q;
    rsp_o.args_pending = wanted_q - got_q;
    rsp_o.display_on   = dsp_en_q;
    rsp_o.disp_start_x = dsx_q;
    rsp_o.disp_start_y = dsy_q;
    rsp_o.hrange_start = hs_q;
    rsp_o.hrange_end   = he_q;
    rsp_o.vrange_start = vs_q;
    rsp_o.vrange_end   = ve_q;
    rsp_o.mode_bits    = mode_q;
  end

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_args: assert property (@(posedge clk_i) disable iff (!rst_ni)
    got_q <= wanted_q) else $error("args over");
  a_xfer_args: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xon_q |-> wanted_q == 2'd0) else $error("copy with args");
  a_fill_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |-> mem_o.we) else $error("fill no write");
endmodule

[rtl/core/gpu_command_port_vram_engine_core.sv]
// top level: gpu command port with frame store engine
//
// channel | signals                      | handshake
// request | start, req_i                 | taken when start && !busy
// result  | done_o, rsp_o                | one cycle strobe, cannot stall
//
// status reads, register writes and argument words go straight to the done
// state, pixel reads pass through a peek state, copy data words write the low
// half then the high half, or only the low half when the copy ends there
// (one frame store write port, one pixel per cycle); a fill writes height *
// rounded width pixels, and gp1 reset sweeps the store to zero
// reset: asynchronous, display registers to defaults, then the store is
// swept to zero with busy high and no result
// the receiver cannot stall, so only the sequencer holds words back
module gpu_command_port_vram_engine_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  gcpv_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output gcpv_pkg::rsp_t rsp_o
);
  import gcpv_pkg::*;

  mem_req_t    mem_req;
  logic [15:0] rdata;

  // sequencer drives every frame store access
  gcpv_seq u_seq (
    .clk_i, .rst_ni, .start_i(start), .req_i, .rdata_i(rdata),
    .busy_o(busy), .done_o, .rsp_o, .mem_o(mem_req)
  );

  gcpv_vram u_vram (
    .clk_i, .req_i(mem_req), .rdata_o(rdata)
  );
endmodule
